// ===== hw/rtl/otp_six_word_encoder_defines.svh =====
// Assertion macros for the checker file of the six-word encoder.
`ifndef OTP_SIX_WORD_ENCODER_DEFINES_SVH
`define OTP_SIX_WORD_ENCODER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define OTP6W_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define OTP6W_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/otp6w_pkg.sv =====
package otp6w_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 11;
  localparam int unsigned FillW = 4;
  localparam int unsigned SumW  = 2;
  localparam int unsigned CntW  = 2;

  // Words pushed into the output queue in one cycle, oldest in slot 0.
  typedef struct packed {
    logic [CntW-1:0]  n;
    logic [WordW-1:0] word0;
    logic             last0;
    logic [WordW-1:0] word1;
    logic             last1;
  } push_t;

  // Outcome of packing one byte against the current accumulator.
  typedef struct packed {
    push_t            words;
    logic [WordW-1:0] pending;
    logic [FillW-1:0] fill;
    logic [SumW-1:0]  sum;
  } pack_res_t;

endpackage

// ===== hw/rtl/otp6w_pack.sv =====
module otp6w_pack (
  input  logic [otp6w_pkg::WordW-1:0] pending_i,
  input  logic [otp6w_pkg::FillW-1:0] fill_i,
  input  logic [otp6w_pkg::SumW-1:0]  sum_i,
  input  logic [otp6w_pkg::ByteW-1:0] data_byte_i,
  input  logic                        last_byte_i,
  output otp6w_pkg::pack_res_t        res_o
);

  logic [3:0]  fill_c;
  logic [10:0] mask_p;
  logic [18:0] acc_a;
  logic [4:0]  fill_a;
  logic        emit_a;
  logic [4:0]  fill_b;
  logic [10:0] word_a;
  logic [18:0] mask_b;
  logic [18:0] acc_b;
  logic [10:0] acc_b11;
  logic [1:0]  sum_n;
  logic [12:0] acc_c;
  logic [4:0]  fill_c2;
  logic        emit_b;
  logic [4:0]  fill_d2;
  logic [10:0] word_b;
  logic [12:0] mask_c;
  logic [12:0] acc_d;
  logic [23:0] pad;
  logic [10:0] word_f;

  always_comb begin
    fill_c  = (fill_i > 4'd10) ? 4'd10 : fill_i;
    mask_p  = (11'd1 << fill_c) - 11'd1;
    acc_a   = {pending_i & mask_p, data_byte_i};
    fill_a  = {1'b0, fill_c} + 5'd8;
    emit_a  = (fill_a >= 5'd11);
    fill_b  = emit_a ? (fill_a - 5'd11) : fill_a;
    word_a  = 11'(acc_a >> fill_b);
    mask_b  = (19'd1 << fill_b) - 19'd1;
    acc_b   = emit_a ? (acc_a & mask_b) : acc_a;
    acc_b11 = acc_b[10:0];

    // checksum: sum of the four bit pairs, wrapping at four
    sum_n = sum_i + data_byte_i[7:6] + data_byte_i[5:4] + data_byte_i[3:2]
          + data_byte_i[1:0];

    // append the checksum after the final byte
    acc_c   = {acc_b11, sum_n};
    fill_c2 = fill_b + 5'd2;
    emit_b  = last_byte_i && (fill_c2 > 5'd11);
    fill_d2 = emit_b ? (fill_c2 - 5'd11) : fill_c2;
    word_b  = 11'(acc_c >> fill_d2);
    mask_c  = (13'd1 << fill_d2) - 13'd1;
    acc_d   = emit_b ? (acc_c & mask_c) : acc_c;
    pad     = {acc_d, 11'd0} >> fill_d2;
    word_f  = pad[10:0];

    res_o.words.n     = 2'({1'b0, emit_a}) + 2'({1'b0, emit_b}) + 2'({1'b0, last_byte_i});
    res_o.words.word0 = emit_a ? word_a : (emit_b ? word_b : word_f);
    res_o.words.last0 = !emit_a && !emit_b && last_byte_i;
    res_o.words.word1 = word_f;
    res_o.words.last1 = 1'b1;

    res_o.pending = last_byte_i ? '0 : acc_b11;
    res_o.fill    = last_byte_i ? '0 : fill_b[3:0];
    res_o.sum     = last_byte_i ? '0 : sum_n;
  end

endmodule

// ===== hw/rtl/otp6w_fifo.sv =====
module otp6w_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  otp6w_pkg::push_t            push_i,
  output logic [otp6w_pkg::CntW-1:0]  space_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [otp6w_pkg::WordW-1:0] word_index_o,
  output logic                        last_word_o
);

  logic [otp6w_pkg::WordW-1:0] ent_word_q [2];
  logic                        ent_last_q [2];
  logic [otp6w_pkg::CntW-1:0]  count_q, count_d;
  logic                        rd_q, rd_d;
  logic                        wr_q, wr_d;
  logic                        pop;

  assign out_valid_o  = (count_q != '0);
  assign pop          = out_valid_o && !out_stall_i;
  assign space_o      = 2'd2 - count_q + 2'({1'b0, pop});
  assign word_index_o = ent_word_q[rd_q];
  assign last_word_o  = ent_last_q[rd_q];

  always_comb begin
    count_d = count_q + push_i.n - 2'({1'b0, pop});
    rd_d    = rd_q ^ pop;
    wr_d    = wr_q ^ push_i.n[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= 1'b0;
      wr_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != '0) begin
      ent_word_q[wr_q] <= push_i.word0;
      ent_last_q[wr_q] <= push_i.last0;
    end
    if (push_i.n == 2'd2) begin
      ent_word_q[!wr_q] <= push_i.word1;
      ent_last_q[!wr_q] <= push_i.last1;
    end
  end

endmodule

// ===== hw/rtl/otp_six_word_encoder.sv =====
// Six-word key encoder: takes key bytes, most significant bit first, and
// repacks them into 11-bit dictionary word indices. A 2-bit checksum (the sum
// of every bit pair of every byte, modulo four) follows the byte marked
// last_byte, the final word is zero-padded on the right and carries
// last_word; an 8-byte key therefore gives six words. Accumulator and
// checksum clear after each last byte, so the next byte opens a new key.
// Throughput is one byte per cycle while the queue has room: a byte is registered
// at the input, is packed by a single pass of combinational logic and pushes up
// to two words into a two-entry output queue, which is drained one word a
// beat. A byte is held (in_stall_o high) only while the queue lacks room for
// the words it makes. With a sink that never stalls, a final byte that
// yields two words stalls the input when the queue already holds two words;
// while the sink stalls with the queue full, any byte that makes a word is
// held for as long as the sink stalls. A byte passes through the input
// register and then the output queue registers before its first word is
// presented. No configuration, no clearing pass after reset.
module otp_six_word_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [otp6w_pkg::ByteW-1:0] data_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [otp6w_pkg::WordW-1:0] word_index_o,
  output logic                        last_word_o
);

  // input register
  logic                        in_valid_q, in_valid_d;
  logic [otp6w_pkg::ByteW-1:0] data_q;
  logic                        last_q;

  // accumulator state across bytes of one key
  logic [otp6w_pkg::WordW-1:0] pending_q;
  logic [otp6w_pkg::FillW-1:0] fill_q;
  logic [otp6w_pkg::SumW-1:0]  sum_q;

  otp6w_pkg::pack_res_t        res;
  otp6w_pkg::push_t            push;
  logic [otp6w_pkg::CntW-1:0]  space;
  logic                        proc;
  logic                        in_take;

  otp6w_pack u_pack (
    .pending_i   (pending_q),
    .fill_i      (fill_q),
    .sum_i       (sum_q),
    .data_byte_i (data_q),
    .last_byte_i (last_q),
    .res_o       (res)
  );

  // process the held byte only when every word it makes fits the queue
  assign proc       = in_valid_q && (res.words.n <= space);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !proc);

  always_comb begin
    push   = res.words;
    push.n = proc ? res.words.n : '0;
  end

  otp6w_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_o      (space),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pending_q  <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      // advance the accumulator once the byte has been packed
      if (proc) begin
        pending_q <= res.pending;
        fill_q    <= res.fill;
        sum_q     <= res.sum;
      end
    end
  end

  // hold the byte while stalled, load a new beat otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

endmodule

// ===== hw/rtl/otp6w_checker.sv =====
`include "otp_six_word_encoder_defines.svh"

module otp6w_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [otp6w_pkg::ByteW-1:0] data_byte_i,
  input logic                        last_byte_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [otp6w_pkg::WordW-1:0] word_index_o,
  input logic                        last_word_o
);

  // hold a stalled output beat
  `OTP6W_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(word_index_o) && $stable(last_word_o)), "stalled output beat changed")

  // keep both sides quiet in the cycle after an edge seen in reset
  `OTP6W_ASSERT_RST(a_rst_quiet, !rst_ni |=> (!out_valid_o && !in_stall_o), "activity during reset")

  // a stall on the input only ever holds a beat already taken
  `OTP6W_ASSERT(a_stall_src, in_stall_o |-> ($past(in_valid_i && !in_stall_o) || $past(in_stall_o)), "input stall without a held byte")

  // an output burst starting from empty comes from a byte taken into the input register and then pushed into the queue
  `OTP6W_ASSERT(a_out_cause, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "output word without an input byte")

  // data_byte_i and last_byte_i are watched only for completeness of the port set
  logic unused_in;
  assign unused_in = ^{data_byte_i, last_byte_i};

endmodule

bind otp_six_word_encoder otp6w_checker u_checker (.*);

// ===== sim/otp_six_word_encoder_test.sv =====
`timescale 1ns / 100ps

module otp_six_word_encoder_test;

  localparam int unsigned BW = otp6w_pkg::ByteW;
  localparam int unsigned WW = otp6w_pkg::WordW;
  localparam int unsigned FW = otp6w_pkg::FillW;
  localparam int unsigned SW = otp6w_pkg::SumW;

  // Stop feeding keys once roughly this many bytes have gone in.
  localparam int unsigned ByteBudget  = 550;
  // Slack after the last expected word to catch any stray trailing word.
  localparam int unsigned DrainCycles = 8;

  // Idling modes for either side of the block.
  localparam int unsigned IdleNone  = 0;
  localparam int unsigned IdleShort = 1;
  localparam int unsigned IdleMixed = 2;

  typedef struct packed {
    logic [WW-1:0] idx;
    logic          fin;
  } enc_word_t;

  // One row of the directed table. Where typed is set, the words are written
  // out by hand; otherwise the packing predictor supplies them.
  typedef struct packed {
    logic [BW-1:0] data;
    logic          fin;
    logic          typed;
    logic [1:0]    n_words;
    logic [WW-1:0] w0;
    logic          l0;
    logic [WW-1:0] w1;
    logic          l1;
  } key_row_t;

  localparam int unsigned NumRows = 23;
  localparam key_row_t DirRows [NumRows] = '{
    // Single zero byte: eight zero bits and a zero checksum, padded.
    '{8'h00, 1'b1, 1'b1, 2'd1, 11'h000, 1'b1, 11'h000, 1'b0},
    // Single 0xFF: pair sum 12 wraps to zero, eight ones then two zeros.
    '{8'hFF, 1'b1, 1'b1, 2'd1, 11'h7F8, 1'b1, 11'h000, 1'b0},
    '{8'h80, 1'b1, 1'b0, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    // Two-byte all-ones key: one full word, then five ones, checksum, pad.
    '{8'hFF, 1'b0, 1'b1, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 2'd2, 11'h7FF, 1'b0, 11'h7C0, 1'b1},
    // Eight-byte all-ones key: the standard six words, checksum fills the
    // last word exactly so no padding word follows.
    '{8'hFF, 1'b0, 1'b1, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 2'd1, 11'h7FF, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 2'd1, 11'h7FF, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 2'd1, 11'h7FF, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 2'd1, 11'h7FF, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 2'd1, 11'h7FF, 1'b0, 11'h000, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 2'd1, 11'h7FC, 1'b1, 11'h000, 1'b0},
    // Four-byte key with mixed content: the checksum straddles a word edge.
    '{8'h12, 1'b0, 1'b0, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'h34, 1'b0, 1'b0, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'h56, 1'b0, 1'b0, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'h78, 1'b1, 1'b0, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    // Four zero bytes: same split, every word zero.
    '{8'h00, 1'b0, 1'b1, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 2'd1, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 2'd1, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'h00, 1'b1, 1'b1, 2'd2, 11'h000, 1'b0, 11'h000, 1'b1},
    '{8'hC0, 1'b1, 1'b0, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0},
    '{8'h7F, 1'b1, 1'b0, 2'd0, 11'h000, 1'b0, 11'h000, 1'b0}
  };

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_valid   = 1'b0;
  logic          in_stall;
  logic [BW-1:0] data_byte  = '0;
  logic          last_byte  = 1'b0;
  logic          out_valid;
  logic          out_stall  = 1'b0;
  logic [WW-1:0] word_index;
  logic          last_word;

  // Predictor copy of the packing state.
  logic [WW-1:0] acc_bits = '0;
  logic [FW-1:0] acc_fill = '0;
  logic [SW-1:0] key_sum  = '0;

  enc_word_t     words_due [$];
  int unsigned   mismatches = 0;
  int unsigned   src_mode   = IdleShort;
  int unsigned   sink_mode  = IdleShort;
  int unsigned   stall_left = 0;

  otp_six_word_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .word_index_o(word_index),
    .last_word_o (last_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] low_ones(input int unsigned n);
    return (32'd1 << n) - 32'd1;
  endfunction

  // No gap in IdleNone; otherwise mostly back-to-back with some short gaps, and long ones in the mixed mode.
  function automatic int unsigned pick_gap(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (mode)
      IdleNone:  return 0;
      IdleShort: return (r < 3) ? $urandom_range(1, 2) : 0;
      default: begin
        if (r < 5) return 0;
        if (r < 8) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
      end
    endcase
  endfunction

  // Pack one byte into the predictor state and return the words it releases.
  // Bits are kept right-aligned; on the last byte the checksum is shifted in
  // behind the data and the tail word is padded with zeros on the right.
  task automatic pack_byte(input logic [BW-1:0] b, input logic fin,
                           output enc_word_t w [2], output int unsigned n);
    logic [31:0] acc;
    int unsigned fl;
    n    = 0;
    w[0] = '0;
    w[1] = '0;
    fl   = (acc_fill > 10) ? 10 : acc_fill;
    key_sum = key_sum + b[7:6] + b[5:4] + b[3:2] + b[1:0];
    acc = ((32'(acc_bits) & low_ones(fl)) << 8) | 32'(b);
    fl += 8;
    if (fl >= WW) begin
      fl -= WW;
      w[n] = '{idx: WW'(acc >> fl), fin: 1'b0};
      n++;
      acc &= low_ones(fl);
    end
    if (!fin) begin
      acc_bits = acc[WW-1:0];
      acc_fill = FW'(fl);
      return;
    end
    acc = (acc << 2) | 32'(key_sum);
    fl += 2;
    // Checksum split across a word edge: emit the full word first.
    if (fl > WW) begin
      fl -= WW;
      w[n] = '{idx: WW'(acc >> fl), fin: 1'b0};
      n++;
      acc &= low_ones(fl);
    end
    w[n] = '{idx: WW'(acc << (WW - fl)), fin: 1'b1};
    n++;
    // Start a fresh key.
    acc_bits = '0;
    acc_fill = '0;
    key_sum  = '0;
  endtask

  // Present one byte and hold it until the block takes the beat. Valid is
  // only dropped when a gap is wanted, so back-to-back beats never see
  // valid lowered and raised in the same step.
  task automatic send_byte(input logic [BW-1:0] b, input logic fin,
                           input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed_and_predict(input logic [BW-1:0] b, input logic fin);
    enc_word_t   w [2];
    int unsigned n;
    send_byte(b, fin, pick_gap(src_mode));
    pack_byte(b, fin, w, n);
    for (int unsigned k = 0; k < n; k++) words_due.push_back(w[k]);
  endtask

  // Output side: check each accepted word against the oldest expectation,
  // then choose the stall for the next cycle.
  always @(posedge clk or negedge rst_n) begin : sink_side
    enc_word_t   due;
    int unsigned len;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $display("%0t ns: word %h last %b with nothing expected",
                   $time, word_index, last_word);
          mismatches++;
        end else begin
          due = words_due.pop_front();
          if (word_index !== due.idx) begin
            $display("%0t ns: word_index expected %h, got %h",
                     $time, due.idx, word_index);
            mismatches++;
          end
          if (last_word !== due.fin) begin
            $display("%0t ns: last_word expected %b, got %b",
                     $time, due.fin, last_word);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        len = pick_gap(sink_mode);
        out_stall  <= (len != 0);
        stall_left <= (len != 0) ? len - 1 : 0;
      end
    end
  end

  initial begin : stimulus
    key_row_t    r;
    enc_word_t   w [2];
    int unsigned n;
    int unsigned sent;
    int unsigned key_len;
    int unsigned pick;
    logic [BW-1:0] b;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed keys: extremes, checksum split, checksum filling a word.
    foreach (DirRows[i]) begin
      r = DirRows[i];
      send_byte(r.data, r.fin, pick_gap(src_mode));
      pack_byte(r.data, r.fin, w, n);
      if (r.typed) begin
        if (r.n_words > 0) words_due.push_back('{idx: r.w0, fin: r.l0});
        if (r.n_words > 1) words_due.push_back('{idx: r.w1, fin: r.l1});
      end else begin
        for (int unsigned k = 0; k < n; k++) words_due.push_back(w[k]);
      end
    end

    // Random keys. Lengths up to eleven bytes land the final fill on every
    // position of a word; a few longer keys exercise long runs.
    sent = NumRows;
    while (sent < ByteBudget) begin
      if ($urandom_range(0, 7) == 0) begin
        src_mode  = $urandom_range(IdleNone, IdleMixed);
        sink_mode = $urandom_range(IdleNone, IdleMixed);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)      key_len = $urandom_range(1, 11);
      else if (pick < 9) key_len = $urandom_range(12, 20);
      else               key_len = $urandom_range(1, 3);
      for (int unsigned j = 0; j < key_len; j++) begin
        pick = $urandom_range(0, 15);
        if (pick == 0)      b = '0;
        else if (pick == 1) b = '1;
        else                b = BW'($urandom);
        feed_and_predict(b, j == key_len - 1);
        sent++;
      end
    end

    // Drain: stop feeding, let the sink run freely until every word is in.
    in_valid  <= 1'b0;
    sink_mode = IdleNone;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("otp_six_word_encoder test passed");
    end else begin
      $display("otp_six_word_encoder test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("otp_six_word_encoder test failed");
    $finish;
  end

endmodule

// ===== otp_six_word_encoder.f =====
+incdir+hw/rtl
hw/rtl/otp6w_pkg.sv
hw/rtl/otp6w_pack.sv
hw/rtl/otp6w_fifo.sv
hw/rtl/otp_six_word_encoder.sv
hw/rtl/otp6w_checker.sv
sim/otp_six_word_encoder_test.sv
